### src/twma_pkg.sv
package twma_pkg;

    localparam int TAPS = 21;
    localparam int HIST = TAPS - 1;
    localparam int PEAK = (TAPS + 1) / 2;

    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 20;
    localparam int FILL_W   = $clog2(HIST + 1);
    localparam int WGT_W    = $clog2(PEAK + 1);
    localparam int PROD_W   = SAMPLE_W + WGT_W + 1;

    function automatic int tap_weight(input int j);
        int a;
        int b;
        a = j + 1;
        b = TAPS - j;
        return (a < b) ? a : b;
    endfunction

    function automatic int weight_sum();
        int s;
        s = 0;
        for (int j = 0; j < TAPS; j++) begin
            s = s + tap_weight(j);
        end
        return s;
    endfunction

    localparam int WSUM  = weight_sum();
    localparam int ACC_W = SAMPLE_W + $clog2(WSUM + 1);
    localparam int MAG_W = ACC_W - 1;
    localparam int NUM_W = MAG_W + 6;
    localparam int DIV   = 2 * WSUM;
    localparam int DIV_L = $clog2(DIV);
    localparam int SH    = NUM_W + DIV_L;
    localparam int RCP_W = NUM_W + 1;
    localparam logic [63:0] RCP_FULL = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];
    localparam int PRD_W = NUM_W + RCP_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic [WGT_W-1:0]           t_weight;

endpackage

### src/triangular_weighted_moving_average.sv
// A beat accepted passes through the round registers r_acc, r_num, r_prod and r_out in order; o_valid rises with r_out.
// Throughput: one sample a cycle while o_stall is low; the cell chain updates on every accepted beat.
// The first TAPS-1 samples after reset fill the window and give no result.
// Reset is synchronous and active low; it clears the fill count and the pipeline valids.
module triangular_weighted_moving_average
    import twma_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [15:0]      i_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_smoothed
);

    logic accept;
    logic full;
    logic [FILL_W-1:0] r_fill;
    t_acc psum [1:HIST+1];
    t_acc acc;
    logic signed [PROD_W-1:0] prod0;

    assign accept = i_valid && !o_stall;
    assign full   = (r_fill == FILL_W'(HIST));

    assign psum[HIST+1] = '0;

    for (genvar k = 1; k <= HIST; k++) begin : g_cell
        twma_cell u_cell (
            .i_clk    (i_clk),
            .i_en     (accept),
            .i_sample (i_sample),
            .i_weight (WGT_W'(tap_weight(k))),
            .i_psum   (psum[k+1]),
            .o_psum   (psum[k])
        );
    end

    assign prod0 = i_sample * $signed({1'b0, WGT_W'(tap_weight(0))});
    assign acc   = t_acc'(prod0) + psum[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept && !full) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    twma_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid && full),
        .o_stall    (o_stall),
        .i_acc      (acc),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_smoothed (o_smoothed)
    );

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HIST))
        else $error("fill count passed the window length");
    a_fill_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !full) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("fill count missed a warm-up beat");
    a_warmup_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> !o_valid)
        else $error("result shown before the window filled");
`endif

endmodule

### src/twma_cell.sv
module twma_cell
    import twma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_sample i_sample,
    input  t_weight i_weight,
    input  t_acc    i_psum,
    output t_acc    o_psum
);

    logic signed [PROD_W-1:0] prod;
    t_acc r_psum;
    t_acc n_psum;

    assign prod   = i_sample * $signed({1'b0, i_weight});
    assign n_psum = i_psum + t_acc'(prod);
    assign o_psum = r_psum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_psum <= n_psum;
        end
    end

endmodule

### src/twma_round.sv
module twma_round
    import twma_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  t_acc                    i_acc,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_smoothed
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    t_acc r_acc;
    logic r_neg2, r_neg3, r_neg4;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] n_num;
    logic [MAG_W-1:0] mag;
    t_acc abs_acc;
    logic [PRD_W-1:0] r_prod;
    logic [OUT_W-1:0] quo;
    logic signed [OUT_W-1:0] r_out;

    assign rdy4 = !r_v4 || !i_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    assign abs_acc = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign mag     = abs_acc[MAG_W-1:0];
    assign n_num   = {1'b0, mag, 5'b0} + NUM_W'(WSUM);
    assign quo     = r_prod[SH +: OUT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_acc <= i_acc;
        end
        if (rdy2 && r_v1) begin
            r_num  <= n_num;
            r_neg2 <= r_acc[ACC_W-1];
        end
        if (rdy3 && r_v2) begin
            r_prod <= r_num * RCP;
            r_neg3 <= r_neg2;
        end
        if (rdy4 && r_v3) begin
            r_out  <= r_neg3 ? -$signed(quo) : $signed(quo);
            r_neg4 <= r_neg3;
        end
    end

    assign o_valid    = r_v4;
    assign o_smoothed = r_out;

`ifndef SYNTHESIS
    a_stall_needs_full_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_stall))
        else $error("input stalled while the pipeline has room");
    a_held_stage_keeps_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !rdy3) |=> (r_v2 && $stable(r_num)))
        else $error("held stage lost its numerator");
    a_sign_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_out != '0) |-> (r_out[OUT_W-1] == r_neg4))
        else $error("result sign does not match the sum sign");
`endif

endmodule
